// ===== rtl/core/cpf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared constants, types and the CRC byte update for the command packet
// framer.
// ----------------------------------------------------------------------------
`default_nettype none

package cpf_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h8005;

  localparam logic [7:0]  HDR_RESET  = 8'h01;

  // Byte positions inside the eight-byte packet
  typedef enum logic [2:0] {
    POS_HDR_FIRST  = 3'd0,
    POS_HDR_SECOND = 3'd1,
    POS_CMD_3      = 3'd2,
    POS_CMD_2      = 3'd3,
    POS_CMD_1      = 3'd4,
    POS_CMD_0      = 3'd5,
    POS_CRC_HI     = 3'd6,
    POS_CRC_LO     = 3'd7
  } pkt_pos_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_HDR_FIRST  = 1'b0,
    CFG_HDR_SECOND = 1'b1
  } cfg_idx_t;

  // Shift one message byte, MSB first, into the low end of the register.
  function automatic logic [15:0] crc_feed_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
    logic [15:0] r;
    logic        top;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      top = r[15];
      r   = {r[14:0], data[i]};
      if (top) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cpf_cmd_if.sv =====
// ----------------------------------------------------------------------------
// cpf_cmd_if
// Valid/ready channel carrying one 32-bit command word per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpf_cmd_if;
  logic        valid;
  logic        ready;
  logic [31:0] command_word;

  modport source (output valid, output command_word, input ready);
  modport sink   (input valid, input command_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cpf_pkt_if.sv =====
// ----------------------------------------------------------------------------
// cpf_pkt_if
// Valid/ready channel carrying one packet byte and its last flag per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpf_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       is_last;

  modport source (output valid, output packet_byte, output is_last, input ready);
  modport sink   (input valid, input packet_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crc16_command_packet_framer.sv =====
// ----------------------------------------------------------------------------
// crc16_command_packet_framer
// Frames a 32-bit command as header, command and CRC-16 bytes.
// ----------------------------------------------------------------------------
// Each accepted command word produces eight byte transactions, MSB first:
// the two header bytes from the configuration registers, the four command
// bytes, then the CRC-16 (poly 0x8005, init 0xFFFF, no final XOR) high byte
// and low byte; is_last marks the eighth byte. The byte output channel sets
// the rate at which commands are taken. A holding register takes the next
// command while the current packet is still going out, so packets follow
// without a gap. While the sink takes bytes, the CRC is updated one byte per
// cycle as bytes one to six leave, so it is ready when byte seven goes. A
// command passes the holding register, the emitter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_command_packet_framer
  import cpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  cpf_cmd_if.sink          in_ch,
  cpf_pkt_if.source        out_ch
);

  // Configuration
  logic [7:0]  hdr_first_r;
  logic [7:0]  hdr_second_r;

  // Input holding register
  logic        hold_v_r;
  logic [31:0] hold_cmd_r;

  // Packet emitter
  logic        busy_r;
  logic [31:0] cmd_r;
  pkt_pos_t    pos_r;
  logic [15:0] crc_r;

  // Output register
  logic        out_v_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        in_fire;
  logic        out_free;
  logic        emit;
  logic        done;
  logic        load;
  logic [7:0]  byte_sel;

  assign in_ch.ready = !hold_v_r;
  assign in_fire     = in_ch.valid && !hold_v_r;

  assign out_free = !out_v_r || out_ch.ready;
  assign emit     = busy_r && out_free;
  assign done     = emit && (pos_r == POS_CRC_LO);
  assign load     = hold_v_r && (!busy_r || done);

  always_comb begin
    case (pos_r)
      POS_HDR_FIRST:  byte_sel = hdr_first_r;
      POS_HDR_SECOND: byte_sel = hdr_second_r;
      POS_CMD_3:      byte_sel = cmd_r[31:24];
      POS_CMD_2:      byte_sel = cmd_r[23:16];
      POS_CMD_1:      byte_sel = cmd_r[15:8];
      POS_CMD_0:      byte_sel = cmd_r[7:0];
      POS_CRC_HI:     byte_sel = crc_r[15:8];
      POS_CRC_LO:     byte_sel = crc_r[7:0];
      default:        byte_sel = crc_r[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HDR_RESET;
      hdr_second_r <= HDR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HDR_FIRST:  hdr_first_r  <= cfg_data;
        CFG_HDR_SECOND: hdr_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_fire) begin
      hold_v_r <= 1'b1;
    end else if (load) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_cmd_r <= in_ch.command_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= POS_HDR_FIRST;
    end else if (load) begin
      busy_r <= 1'b1;
      pos_r  <= POS_HDR_FIRST;
    end else if (emit) begin
      busy_r <= !done;
      pos_r  <= pkt_pos_t'(pos_r + 3'd1);
    end
  end

  // Fold each of the first six bytes into the CRC as it leaves
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= hold_cmd_r;
      crc_r <= CRC_INIT;
    end else if (emit && (pos_r != POS_CRC_HI) && (pos_r != POS_CRC_LO)) begin
      crc_r <= crc_feed_byte(crc_r, byte_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= (pos_r == POS_CRC_LO);
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.packet_byte = out_byte_r;
  assign out_ch.is_last     = out_last_r;

endmodule

`default_nettype wire
